[rtl/usrp_pkg.sv]
// ----------------------------------------------------------------------------
// usrp_pkg: UPS status reply parser shared definitions
// Character codes, line positions, result codes, word types and decode helpers.
// ----------------------------------------------------------------------------
package usrp_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_2  = 8'h32;
  localparam logic [7:0] CH_3  = 8'h33;

  localparam int         CNT_W     = 5;
  localparam logic [4:0] LINE_LEN  = 5'd21;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  // character positions within the reply line
  localparam logic [4:0] POS_BATT    = 5'd0;
  localparam logic [4:0] POS_LOAD    = 5'd1;
  localparam logic [4:0] POS_VOLT_HI = 5'd2;
  localparam logic [4:0] POS_VOLT_LO = 5'd3;
  localparam logic [4:0] POS_TAP     = 5'd4;
  localparam logic [4:0] POS_MODE    = 5'd5;
  localparam logic [4:0] POS_TEMP_HI = 5'd6;
  localparam logic [4:0] POS_TEMP_LO = 5'd7;
  localparam logic [4:0] POS_LPCT_HI = 5'd12;
  localparam logic [4:0] POS_LPCT_LO = 5'd13;
  localparam logic [4:0] POS_FREQ_0  = 5'd18;
  localparam logic [4:0] POS_FREQ_1  = 5'd19;
  localparam logic [4:0] POS_FREQ_2  = 5'd20;

  // hex field end flags
  localparam int FE_VOLT = 0;
  localparam int FE_TEMP = 1;
  localparam int FE_LPCT = 2;
  localparam int FE_FREQ = 3;

  localparam logic [1:0] LEN_OK    = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  localparam logic [1:0] TAP_NORMAL  = 2'd0;
  localparam logic [1:0] TAP_TRIM    = 2'd1;
  localparam logic [1:0] TAP_BOOST   = 2'd2;
  localparam logic [1:0] TAP_UNKNOWN = 2'd3;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_BATTERY = 2'd1;
  localparam logic [1:0] MODE_ONLINE  = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  // raw*909/2500 == (raw*TEMP_RECIP) >> TEMP_SHIFT exactly for 8-bit raw
  localparam logic [18:0] TEMP_RECIP    = 19'd381263;
  localparam int          TEMP_SHIFT    = 20;
  localparam logic [7:0]  TEMP_POS_RAW  = 8'd58;
  localparam logic signed [7:0] TEMP_OFS = 8'sd21;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_command;
  } item_t;

  typedef struct packed {
    logic [1:0]        length_status;
    logic              low_battery;
    logic              overload;
    logic [1:0]        tap_state;
    logic [1:0]        ups_mode;
    logic              battery_code_unknown;
    logic              load_code_unknown;
    logic [7:0]        input_voltage;
    logic signed [7:0] temperature_c;
    logic [7:0]        load_percent;
    logic [11:0]       frequency_tenths;
  } result_t;

  // {not_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b0, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

  // trunc((raw*3636 - 210000) / 10000); raw*909 is never a multiple of 2500
  // for raw != 0, so the negative side is floor + 1
  function automatic logic signed [7:0] temp_from_raw(input logic [7:0] raw);
    logic [26:0] prod;
    logic [6:0]  fl;
    logic signed [7:0] t;
    prod = raw * TEMP_RECIP;
    fl   = prod[26:TEMP_SHIFT];
    if (raw >= TEMP_POS_RAW) begin
      t = $signed({1'b0, fl}) - TEMP_OFS;
    end else if (raw == 8'd0) begin
      t = -TEMP_OFS;
    end else begin
      t = $signed({1'b0, fl}) - TEMP_OFS + 8'sd1;
    end
    return t;
  endfunction

endpackage

[rtl/usrp_if.sv]
// ----------------------------------------------------------------------------
// usrp_if: UPS status reply parser channel interfaces
// Valid/ready channels for received bytes and for decoded status words.
// ----------------------------------------------------------------------------
interface usrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_command;

  modport source (output valid, output rx_byte, output new_command, input ready);
  modport sink   (input valid, input rx_byte, input new_command, output ready);
endinterface

interface usrp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        length_status;
  logic              low_battery;
  logic              overload;
  logic [1:0]        tap_state;
  logic [1:0]        ups_mode;
  logic              battery_code_unknown;
  logic              load_code_unknown;
  logic [7:0]        input_voltage;
  logic signed [7:0] temperature_c;
  logic [7:0]        load_percent;
  logic [11:0]       frequency_tenths;

  modport source (
    output valid, input ready,
    output length_status, output low_battery, output overload, output tap_state,
    output ups_mode, output battery_code_unknown, output load_code_unknown,
    output input_voltage, output temperature_c, output load_percent,
    output frequency_tenths
  );
  modport sink (
    input valid, output ready,
    input length_status, input low_battery, input overload, input tap_state,
    input ups_mode, input battery_code_unknown, input load_code_unknown,
    input input_voltage, input temperature_c, input load_percent,
    input frequency_tenths
  );
endinterface

[rtl/usrp_in_reg.sv]
// ----------------------------------------------------------------------------
// usrp_in_reg: input word register
// Captures one received byte word; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module usrp_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  usrp_in_if.sink            in_ch,
  input  logic               item_take,
  output logic               item_valid,
  output usrp_pkg::item_t    item
);

  logic            valid_r;
  logic            valid_nxt;
  usrp_pkg::item_t item_r;
  logic            accept;

  assign in_ch.ready = !valid_r || item_take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.rx_byte     <= in_ch.rx_byte;
      item_r.new_command <= in_ch.new_command;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/usrp_parse.sv]
// ----------------------------------------------------------------------------
// usrp_parse: line state and status decode
// Echo skip, character collection, hex accumulation and result decode.
// ----------------------------------------------------------------------------
module usrp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  usrp_pkg::item_t    item,
  input  logic               out_free,
  output logic               item_take,
  output logic               res_load,
  output usrp_pkg::result_t  result
);

  logic        collecting_r, collecting_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [7:0]  batt_r, batt_nxt;
  logic [7:0]  lstate_r, lstate_nxt;
  logic [7:0]  tap_r, tap_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  volt_r, volt_nxt;
  logic [7:0]  temp_r, temp_nxt;
  logic [7:0]  lpct_r, lpct_nxt;
  logic [11:0] freq_r, freq_nxt;
  logic [3:0]  ended_r, ended_nxt;

  logic [7:0] c;
  logic       is_lf;
  logic       is_cr;
  logic       col_eff;
  logic       emit;
  logic       clr;
  logic [4:0] dig;

  always_comb begin
    c       = item.rx_byte;
    is_lf   = (c == usrp_pkg::CH_LF);
    is_cr   = (c == usrp_pkg::CH_CR);
    col_eff = collecting_r && !item.new_command;
    emit    = col_eff && is_lf;
    item_take = item_valid && (!emit || out_free);
    res_load  = item_take && emit;
    dig     = usrp_pkg::hex_digit(c);
    clr     = item.new_command || is_lf;

    collecting_nxt = collecting_r;
    cnt_nxt    = cnt_r;
    batt_nxt   = batt_r;
    lstate_nxt = lstate_r;
    tap_nxt    = tap_r;
    mode_nxt   = mode_r;
    volt_nxt   = volt_r;
    temp_nxt   = temp_r;
    lpct_nxt   = lpct_r;
    freq_nxt   = freq_r;
    ended_nxt  = ended_r;

    if (item.new_command) begin
      collecting_nxt = 1'b0;
    end
    if (!col_eff) begin
      if (is_lf) begin
        collecting_nxt = 1'b1;
      end
    end else if (is_lf) begin
      collecting_nxt = 1'b0;
    end else if (!is_cr) begin
      case (cnt_r)
        usrp_pkg::POS_BATT: batt_nxt   = c;
        usrp_pkg::POS_LOAD: lstate_nxt = c;
        usrp_pkg::POS_TAP:  tap_nxt    = c;
        usrp_pkg::POS_MODE: mode_nxt   = c;
        usrp_pkg::POS_VOLT_HI, usrp_pkg::POS_VOLT_LO: begin
          if (!ended_r[usrp_pkg::FE_VOLT]) begin
            if (dig[4]) ended_nxt[usrp_pkg::FE_VOLT] = 1'b1;
            else volt_nxt = {volt_r[3:0], dig[3:0]};
          end
        end
        usrp_pkg::POS_TEMP_HI, usrp_pkg::POS_TEMP_LO: begin
          if (!ended_r[usrp_pkg::FE_TEMP]) begin
            if (dig[4]) ended_nxt[usrp_pkg::FE_TEMP] = 1'b1;
            else temp_nxt = {temp_r[3:0], dig[3:0]};
          end
        end
        usrp_pkg::POS_LPCT_HI, usrp_pkg::POS_LPCT_LO: begin
          if (!ended_r[usrp_pkg::FE_LPCT]) begin
            if (dig[4]) ended_nxt[usrp_pkg::FE_LPCT] = 1'b1;
            else lpct_nxt = {lpct_r[3:0], dig[3:0]};
          end
        end
        usrp_pkg::POS_FREQ_0, usrp_pkg::POS_FREQ_1, usrp_pkg::POS_FREQ_2: begin
          if (!ended_r[usrp_pkg::FE_FREQ]) begin
            if (dig[4]) ended_nxt[usrp_pkg::FE_FREQ] = 1'b1;
            else freq_nxt = {freq_r[7:0], dig[3:0]};
          end
        end
        default: ;
      endcase
      if (cnt_r != usrp_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + 5'd1;
      end
    end

    if (clr) begin
      cnt_nxt    = '0;
      batt_nxt   = '0;
      lstate_nxt = '0;
      tap_nxt    = '0;
      mode_nxt   = '0;
      volt_nxt   = '0;
      temp_nxt   = '0;
      lpct_nxt   = '0;
      freq_nxt   = '0;
      ended_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      cnt_r        <= '0;
      ended_r      <= '0;
    end else if (item_take) begin
      collecting_r <= collecting_nxt;
      cnt_r        <= cnt_nxt;
      ended_r      <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      batt_r   <= batt_nxt;
      lstate_r <= lstate_nxt;
      tap_r    <= tap_nxt;
      mode_r   <= mode_nxt;
      volt_r   <= volt_nxt;
      temp_r   <= temp_nxt;
      lpct_r   <= lpct_nxt;
      freq_r   <= freq_nxt;
    end
  end

  // result from the line held so far; fields stay zero on a bad length
  always_comb begin
    result = '0;
    if (cnt_r < usrp_pkg::LINE_LEN) begin
      result.length_status = usrp_pkg::LEN_SHORT;
    end else if (cnt_r > usrp_pkg::LINE_LEN) begin
      result.length_status = usrp_pkg::LEN_LONG;
    end else begin
      result.length_status = usrp_pkg::LEN_OK;
      result.low_battery   = (batt_r == usrp_pkg::CH_0);
      result.overload      = (lstate_r == usrp_pkg::CH_0);
      case (tap_r)
        usrp_pkg::CH_0:                 result.tap_state = usrp_pkg::TAP_NORMAL;
        usrp_pkg::CH_1:                 result.tap_state = usrp_pkg::TAP_TRIM;
        usrp_pkg::CH_2, usrp_pkg::CH_3: result.tap_state = usrp_pkg::TAP_BOOST;
        default:                        result.tap_state = usrp_pkg::TAP_UNKNOWN;
      endcase
      case (mode_r)
        usrp_pkg::CH_0:                 result.ups_mode = usrp_pkg::MODE_OFF;
        usrp_pkg::CH_1, usrp_pkg::CH_3: result.ups_mode = usrp_pkg::MODE_BATTERY;
        usrp_pkg::CH_2:                 result.ups_mode = usrp_pkg::MODE_ONLINE;
        default:                        result.ups_mode = usrp_pkg::MODE_UNKNOWN;
      endcase
      result.battery_code_unknown = (batt_r != usrp_pkg::CH_0) && (batt_r != usrp_pkg::CH_1);
      result.load_code_unknown    = (lstate_r != usrp_pkg::CH_0) &&
                                    (lstate_r != usrp_pkg::CH_1);
      result.input_voltage    = volt_r;
      result.temperature_c    = usrp_pkg::temp_from_raw(temp_r);
      result.load_percent     = lpct_r;
      result.frequency_tenths = freq_r;
    end
  end

endmodule

[rtl/usrp_out_reg.sv]
// ----------------------------------------------------------------------------
// usrp_out_reg: result word register
// Holds a decoded status word until the sink takes it.
// ----------------------------------------------------------------------------
module usrp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_load,
  input  usrp_pkg::result_t  result,
  output logic               out_free,
  usrp_out_if.source         out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  usrp_pkg::result_t data_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid                = valid_r;
  assign out_ch.length_status        = data_r.length_status;
  assign out_ch.low_battery          = data_r.low_battery;
  assign out_ch.overload             = data_r.overload;
  assign out_ch.tap_state            = data_r.tap_state;
  assign out_ch.ups_mode             = data_r.ups_mode;
  assign out_ch.battery_code_unknown = data_r.battery_code_unknown;
  assign out_ch.load_code_unknown    = data_r.load_code_unknown;
  assign out_ch.input_voltage        = data_r.input_voltage;
  assign out_ch.temperature_c        = data_r.temperature_c;
  assign out_ch.load_percent         = data_r.load_percent;
  assign out_ch.frequency_tenths     = data_r.frequency_tenths;

endmodule

[rtl/ups_status_reply_parser.sv]
// ----------------------------------------------------------------------------
// ups_status_reply_parser: UPS status reply line parser
// Skips the command echo, collects the reply line and decodes status words.
//
//   channel  dir  word                               handshake
//   in_ch    in   rx_byte, new_command               valid/ready
//   out_ch   out  length verdict, status, hex fields valid/ready
//
// One byte per cycle unless stalled: input register, decode, result register.
// A line feed ending a reply loads the result register; other bytes only
// update line state. in_ch stalls only when a reply line feed waits on a
// full result register. Synchronous active-low reset clears all valids and
// returns the parser to echo skipping.
// ----------------------------------------------------------------------------
module ups_status_reply_parser (
  input  logic        clk,
  input  logic        rst_n,
  usrp_in_if.sink     in_ch,
  usrp_out_if.source  out_ch
);

  logic              item_valid;
  usrp_pkg::item_t   item;
  logic              item_take;
  logic              res_load;
  logic              out_free;
  usrp_pkg::result_t result;

  usrp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  usrp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_load   (res_load),
    .result     (result)
  );

  usrp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (res_load),
    .result   (result),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

[rtl/usrp_chk.sv]
// ----------------------------------------------------------------------------
// usrp_chk: port-level checks for the status reply parser
// Output handshake, reset behavior and result word consistency.
// ----------------------------------------------------------------------------
module usrp_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        length_status,
  input logic              low_battery,
  input logic              overload,
  input logic [1:0]        tap_state,
  input logic [1:0]        ups_mode,
  input logic              battery_code_unknown,
  input logic              load_code_unknown,
  input logic [7:0]        input_voltage,
  input logic signed [7:0] temperature_c,
  input logic [7:0]        load_percent,
  input logic [11:0]       frequency_tenths
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(input_voltage) && $stable(temperature_c) &&
      $stable(load_percent) && $stable(frequency_tenths) && $stable(length_status))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (length_status == usrp_pkg::LEN_SHORT ||
      length_status == usrp_pkg::LEN_LONG) |->
      !low_battery && !overload && tap_state == usrp_pkg::TAP_NORMAL &&
      ups_mode == usrp_pkg::MODE_OFF &&
      !battery_code_unknown && !load_code_unknown && input_voltage == 8'd0 &&
      temperature_c == 8'sd0 && load_percent == 8'd0 && frequency_tenths == 12'd0)
    else $error("decoded fields on a bad-length line");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && length_status == usrp_pkg::LEN_OK |->
      temperature_c >= -8'sd21 && temperature_c <= 8'sd71)
    else $error("temperature out of range");

endmodule

bind ups_status_reply_parser usrp_chk u_usrp_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .length_status        (out_ch.length_status),
  .low_battery          (out_ch.low_battery),
  .overload             (out_ch.overload),
  .tap_state            (out_ch.tap_state),
  .ups_mode             (out_ch.ups_mode),
  .battery_code_unknown (out_ch.battery_code_unknown),
  .load_code_unknown    (out_ch.load_code_unknown),
  .input_voltage        (out_ch.input_voltage),
  .temperature_c        (out_ch.temperature_c),
  .load_percent         (out_ch.load_percent),
  .frequency_tenths     (out_ch.frequency_tenths)
);

[bench/ups_status_reply_parser_checker.sv]
// ----------------------------------------------------------------------------
// ups_status_reply_parser_checker: status word predictor and scoreboard
// Watches both channels. Every accepted byte updates a private copy of the line
// state; a reply line feed queues the status word it should produce. Each
// accepted status word is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module ups_status_reply_parser_checker (
  input  logic clk,
  input  logic rst_n,
  usrp_in_if   in_ch,
  usrp_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  localparam int REPORT_LIMIT = 10;

  logic        collecting;
  logic [4:0]  char_cnt;
  logic [7:0]  batt_c, load_c, tap_c, mode_c;
  logic [11:0] volt_acc, temp_acc, lpct_acc, freq_acc;
  logic [3:0]  field_done;

  usrp_pkg::result_t expected_status[$];
  usrp_pkg::result_t seen, want;
  int      mismatches = 0;
  int      words_out = 0;

  function automatic void clear_line();
    char_cnt   = '0;
    batt_c     = '0;
    load_c     = '0;
    tap_c      = '0;
    mode_c     = '0;
    volt_acc   = '0;
    temp_acc   = '0;
    lpct_acc   = '0;
    freq_acc   = '0;
    field_done = '0;
  endfunction

  // first non-hex character closes the field for good
  task automatic shift_hex(inout logic [11:0] acc, input int fe, input logic [11:0] mask,
                           input logic [7:0] c);
    logic [3:0] v;
    logic       ok;
    ok = 1'b1;
    v  = '0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
    end else begin
      ok = 1'b0;
    end
    if (!field_done[fe]) begin
      if (ok) begin
        acc = ((acc << 4) | 12'(v)) & mask;
      end else begin
        field_done[fe] = 1'b1;
      end
    end
  endtask

  task automatic track_line(input logic [7:0] c, input logic restart);
    usrp_pkg::result_t r;
    int      t;
    if (restart) begin
      collecting = 1'b0;
      clear_line();
    end
    if (!collecting) begin
      if (c == usrp_pkg::CH_LF) begin
        collecting = 1'b1;
        clear_line();
      end
    end else if (c == usrp_pkg::CH_LF) begin
      r = '0;
      if (char_cnt < usrp_pkg::LINE_LEN) begin
        r.length_status = usrp_pkg::LEN_SHORT;
      end else if (char_cnt > usrp_pkg::LINE_LEN) begin
        r.length_status = usrp_pkg::LEN_LONG;
      end else begin
        r.length_status        = usrp_pkg::LEN_OK;
        r.low_battery          = (batt_c == usrp_pkg::CH_0);
        r.overload             = (load_c == usrp_pkg::CH_0);
        r.battery_code_unknown = (batt_c != usrp_pkg::CH_0 && batt_c != usrp_pkg::CH_1);
        r.load_code_unknown    = (load_c != usrp_pkg::CH_0 && load_c != usrp_pkg::CH_1);
        case (tap_c)
          usrp_pkg::CH_0:                 r.tap_state = usrp_pkg::TAP_NORMAL;
          usrp_pkg::CH_1:                 r.tap_state = usrp_pkg::TAP_TRIM;
          usrp_pkg::CH_2, usrp_pkg::CH_3: r.tap_state = usrp_pkg::TAP_BOOST;
          default:                        r.tap_state = usrp_pkg::TAP_UNKNOWN;
        endcase
        case (mode_c)
          usrp_pkg::CH_0:                 r.ups_mode = usrp_pkg::MODE_OFF;
          usrp_pkg::CH_1, usrp_pkg::CH_3: r.ups_mode = usrp_pkg::MODE_BATTERY;
          usrp_pkg::CH_2:                 r.ups_mode = usrp_pkg::MODE_ONLINE;
          default:                        r.ups_mode = usrp_pkg::MODE_UNKNOWN;
        endcase
        r.input_voltage    = volt_acc[7:0];
        t                  = (int'(temp_acc[7:0]) * 3636 - 210000) / 10000;
        r.temperature_c    = 8'(t);
        r.load_percent     = lpct_acc[7:0];
        r.frequency_tenths = freq_acc;
      end
      expected_status.push_back(r);
      collecting = 1'b0;
      clear_line();
    end else if (c != usrp_pkg::CH_CR) begin
      case (char_cnt)
        usrp_pkg::POS_BATT: batt_c = c;
        usrp_pkg::POS_LOAD: load_c = c;
        usrp_pkg::POS_TAP:  tap_c  = c;
        usrp_pkg::POS_MODE: mode_c = c;
        usrp_pkg::POS_VOLT_HI, usrp_pkg::POS_VOLT_LO:
          shift_hex(volt_acc, usrp_pkg::FE_VOLT, 12'h0FF, c);
        usrp_pkg::POS_TEMP_HI, usrp_pkg::POS_TEMP_LO:
          shift_hex(temp_acc, usrp_pkg::FE_TEMP, 12'h0FF, c);
        usrp_pkg::POS_LPCT_HI, usrp_pkg::POS_LPCT_LO:
          shift_hex(lpct_acc, usrp_pkg::FE_LPCT, 12'h0FF, c);
        usrp_pkg::POS_FREQ_0, usrp_pkg::POS_FREQ_1, usrp_pkg::POS_FREQ_2:
          shift_hex(freq_acc, usrp_pkg::FE_FREQ, 12'hFFF, c);
        default: ;
      endcase
      if (char_cnt != usrp_pkg::COUNT_MAX) char_cnt++;
    end
  endtask

  function automatic string show_status(input usrp_pkg::result_t s);
    return $sformatf({"len=%0d lowbat=%0d ovl=%0d tap=%0d mode=%0d bunk=%0d lunk=%0d",
                      " v=%0d t=%0d l=%0d f=%0d"},
                     s.length_status, s.low_battery, s.overload, s.tap_state, s.ups_mode,
                     s.battery_code_unknown, s.load_code_unknown, s.input_voltage,
                     s.temperature_c, s.load_percent, s.frequency_tenths);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      collecting = 1'b0;
      clear_line();
      expected_status.delete();
    end else begin
      // a word leaving now came from an earlier byte, so compare before predicting
      if (out_ch.valid && out_ch.ready) begin
        seen = '{length_status: out_ch.length_status, low_battery: out_ch.low_battery,
                 overload: out_ch.overload, tap_state: out_ch.tap_state,
                 ups_mode: out_ch.ups_mode,
                 battery_code_unknown: out_ch.battery_code_unknown,
                 load_code_unknown: out_ch.load_code_unknown,
                 input_voltage: out_ch.input_voltage, temperature_c: out_ch.temperature_c,
                 load_percent: out_ch.load_percent,
                 frequency_tenths: out_ch.frequency_tenths};
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected status word %0d\n  expected none\n  actual   %s",
                     words_out, show_status(seen));
        end else begin
          want = expected_status.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("status word %0d mismatch\n  expected %s\n  actual   %s",
                       words_out, show_status(want), show_status(seen));
          end
        end
        words_out++;
      end
      if (in_ch.valid && in_ch.ready) track_line(in_ch.rx_byte, in_ch.new_command);
    end
    pending    = expected_status.size();
    fail_count = mismatches;
  end

endmodule

[bench/ups_status_reply_parser_tb.sv]
// ----------------------------------------------------------------------------
// ups_status_reply_parser_tb: UPS status reply parser testbench
// Sends command echoes and reply lines (directed corner lines first, then
// random well-formed, mis-sized and broken lines plus noise) with random
// gaps on both channels; the checker predicts and compares every status word.
// ----------------------------------------------------------------------------
module ups_status_reply_parser_tb;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         ITEM_COUNT  = 1250;
  localparam int         TAIL_CYCLES = 16;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   sent_words = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;

  usrp_in_if  in_ch ();
  usrp_out_if out_ch ();

  ups_status_reply_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ups_status_reply_parser_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // anything but a line end
  function automatic logic [7:0] line_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == usrp_pkg::CH_LF || c == usrp_pkg::CH_CR);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return usrp_pkg::CH_0 + 8'(d);
    return 8'(d - 10) + ($urandom_range(0, 1) ? "A" : "a");
  endfunction

  function automatic logic [7:0] reply_char(input int pos);
    if (pos >= usrp_pkg::LINE_LEN) return line_char();
    case (5'(pos))
      usrp_pkg::POS_BATT, usrp_pkg::POS_LOAD, usrp_pkg::POS_TAP, usrp_pkg::POS_MODE:
        return ($urandom_range(0, 99) < 80) ?
               usrp_pkg::CH_0 + 8'($urandom_range(0, 3)) : line_char();
      usrp_pkg::POS_VOLT_HI, usrp_pkg::POS_VOLT_LO, usrp_pkg::POS_TEMP_HI,
      usrp_pkg::POS_TEMP_LO, usrp_pkg::POS_LPCT_HI, usrp_pkg::POS_LPCT_LO,
      usrp_pkg::POS_FREQ_0, usrp_pkg::POS_FREQ_1, usrp_pkg::POS_FREQ_2:
        return ($urandom_range(0, 99) < 88) ? hex_char() : line_char();
      default:
        return $urandom_range(0, 1) ? CH_SPACE : line_char();
    endcase
  endfunction

  // returns at the rising edge that accepts the word
  task automatic put_word(input logic [7:0] b, input logic restart);
    int gap;
    if ($urandom_range(0, 79) == 0) calm_in = !calm_in;
    gap = pick_gap(calm_in);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.rx_byte     = b;
    in_ch.new_command = restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b0);
  endtask

  task automatic send_echo(input bit restart);
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++)
      put_word(($urandom_range(0, 9) == 0) ? usrp_pkg::CH_CR : line_char(),
               restart && i == 0);
    put_word(usrp_pkg::CH_LF, restart && n == 0);
  endtask

  task automatic send_reply(input int len, input int cut_at);
    for (int pos = 0; pos < len; pos++) begin
      if ($urandom_range(0, 19) == 0) put_word(usrp_pkg::CH_CR, 1'b0);
      put_word(reply_char(pos), pos == cut_at);
    end
    if ($urandom_range(0, 1)) put_word(usrp_pkg::CH_CR, 1'b0);
    put_word(usrp_pkg::CH_LF, 1'b0);
  endtask

  initial begin : out_ready_drive
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall        = pick_gap(calm_out);
      end
    end
  end

  initial begin
    int kind, len, n;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    in_ch.new_command = 1'b0;
    rst_n             = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // text before the first line feed is echo; then an empty reply
    send_text("00FF\n\n");
    send_text("S\r\n");
    send_text("00FF00FF0000FF0000FFF\r\n");
    send_text("S\n");
    send_text("110011000000000000000\n");
    send_text("S\n");
    send_text("10ab223A 12 Cdxyzw1e3\n");
    send_text("S\n");
    send_text("Z?G53339....5Z....7q9\n");
    send_text("S\n");
    send_text("11FFXY01xxxxABxxxx12\r3\n");
    send_text("S\n");
    put_word(CH_NUL, 1'b0);
    send_text("14");
    put_word(CH_NUL, 1'b0);
    send_text("00FF0000FF0000FFF\n");
    send_text("S\n");
    send_text("00FF00FF0000FF0000FF\n");
    send_text("S\n");
    send_text("00FF00FF0000FF0000FFFF\n");
    send_text("S\n");
    send_text("AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA\n");
    // restart in the middle of a reply, then on a line feed
    send_text("S\n0101");
    put_word(line_char(), 1'b1);
    send_text("\n00FF00FF0000FF0000FFF\n");
    put_word(usrp_pkg::CH_LF, 1'b1);
    send_text("00FF00FF0000FF0000FFF\n");
    // a reply right after a result is taken as echo
    send_text("110011000000000000000\n");
    send_text("10ab223A 12 Cdxyzw1e3\n");

    while (sent_words < ITEM_COUNT) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        send_echo($urandom_range(0, 3) == 0);
        send_reply(usrp_pkg::LINE_LEN,
                   ($urandom_range(0, 24) == 0) ? $urandom_range(0, 20) : -1);
      end else if (kind < 88) begin
        send_echo($urandom_range(0, 3) == 0);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(18, 24);
        send_reply(len, -1);
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          put_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
